FILE: sv/hftd_pkg.sv
// Shared types, constants and a helper function for the heightfield triangle distance unit.
package hftd_pkg;

    // Grid geometry
    localparam int GRID_COLS   = 64;
    localparam int GRID_ROWS   = 64;
    localparam int GRID_DEPTH  = GRID_COLS * GRID_ROWS;
    localparam int GRID_ADDR_W = $clog2(GRID_DEPTH);
    localparam int IDX_W       = 6;

    // Item kinds on tuser
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_PLANE = 2'd1;
    localparam logic [1:0] FUNC_DIR   = 2'd2;
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    // Result status codes on tuser
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CLAMPED  = 2'd1;
    localparam logic [1:0] ST_PARALLEL = 2'd2;
    localparam logic [1:0] ST_LOADED   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_INV_SP_X = 3'd2;
    localparam logic [2:0] CFG_INV_SP_Y = 3'd3;
    localparam logic [2:0] CFG_COLS     = 3'd4;
    localparam logic [2:0] CFG_ROWS     = 3'd5;

    // Result range and divider length
    localparam int          VAL_W     = 52;
    localparam int          DIV_STEPS = 52;
    localparam logic [51:0] VAL_MAX   = 52'h7FFFFFFFFFFFF;
    localparam logic [51:0] VAL_CAP   = 52'h8000000000000;

    // Per-axis cell location
    typedef struct packed {
        logic [IDX_W-1:0] cell_idx;
        logic [16:0]      frac;
        logic             clamped;
    } loc_t;

    // One step of the restoring divider, with the item's pass-through result
    typedef struct packed {
        logic        valid;
        logic        divide;
        logic        neg;
        logic        ovf;
        logic [1:0]  status;
        logic [51:0] value;
        logic [50:0] ud;
        logic [50:0] rem;
        logic [21:0] un_lo;
        logic [51:0] q;
    } div_stage_t;

    // Cell index and fraction along one axis from the Q16.16 product
    function automatic loc_t hftd_locate(input logic signed [32:0] prod,
                                         input logic [6:0] cnt,
                                         input logic [6:0] limit);
        logic [6:0]         n;
        logic [6:0]         last;
        logic signed [16:0] ip;
        loc_t               r;
        n  = cnt;
        if (n < 7'd2)
            n = 7'd2;
        if (n > limit)
            n = limit;
        last = n - 7'd2;
        ip   = prod[32:16];
        if (ip[16])
        begin
            r.cell_idx = '0;
            r.frac     = '0;
            r.clamped  = 1'b1;
        end
        else if (ip > $signed({10'd0, last}))
        begin
            r.cell_idx = last[IDX_W-1:0];
            r.frac     = 17'h10000;
            r.clamped  = 1'b1;
        end
        else
        begin
            r.cell_idx = ip[IDX_W-1:0];
            r.frac     = {1'b0, prod[15:0]};
            r.clamped  = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: sv/hftd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hftd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/hftd_divider.sv
// Pipelined restoring divider: one quotient bit per stage.
module hftd_divider
    import hftd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  div_stage_t in_stage,
    output div_stage_t out_stage
);

    div_stage_t stage_in   [DIV_STEPS];
    div_stage_t stage_next [DIV_STEPS];
    div_stage_t stage_reg  [DIV_STEPS];

    assign stage_in[0] = in_stage;

    genvar i;
    generate
        for (i = 0; i < DIV_STEPS; i++)
        begin : g_step
            if (i > 0)
            begin : g_link
                assign stage_in[i] = stage_reg[i-1];
            end

            // shift in next dividend bit, trial subtract
            always_comb
            begin
                logic [51:0] rem_sh;
                logic        ge;
                rem_sh = {stage_in[i].rem, stage_in[i].un_lo[21]};
                ge     = rem_sh >= {1'b0, stage_in[i].ud};
                stage_next[i]       = stage_in[i];
                stage_next[i].un_lo = {stage_in[i].un_lo[20:0], 1'b0};
                stage_next[i].q     = {stage_in[i].q[50:0], ge};
                if (ge)
                    stage_next[i].rem = 51'(rem_sh - {1'b0, stage_in[i].ud});
                else
                    stage_next[i].rem = rem_sh[50:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    stage_reg[i].valid <= 1'b0;
                else if (en)
                    stage_reg[i] <= stage_next[i];
            end
        end
    endgenerate

    assign out_stage = stage_reg[DIV_STEPS-1];

endmodule

FILE: sv/heightfield_triangle_distance_unit.sv
// Top level of the heightfield triangle distance unit.
//
// Usage:
//   s_axis carries items: tuser is the kind (load, plane query, directional
//   query), tdata the grid position, point and direction. Every item gives
//   one result on m_axis: tdata the value, Q22.30 if divided, tuser the status.
//   The cfg channel writes origin, inverse spacing and grid counts; it is
//   always ready and is to be used only while no item is in flight.
// Throughput: one item per cycle unless a result stall holds the pipeline,
//   set by a fully pipelined datapath with a 52-stage one-bit-per-stage
//   divider and three grid RAM copies, one per triangle corner read.
// Loads write the grid in the same stage at which queries read it, so a
//   query sees every load accepted before it.
// Reset: clears all valid bits and returns the config registers to their
//   reset values; grid contents stay undefined until loaded.
// Stall: the whole pipeline holds while a result waits and m_axis_tready is
//   low; s_axis_tready drops at the same time, nothing is lost or repeated.
module heightfield_triangle_distance_unit
    import hftd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // grid_col[5:0], grid_row[11:6], px[27:12], py[43:28], pz[59:44],
    // dx[75:60], dy[91:76], dz[107:92], zero fill [111:108]
    input  logic [111:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // distance_value[51:0], zero fill [55:52]
    output logic [55:0]  m_axis_tdata,
    // status[1:0]
    output logic [1:0]   m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    logic en;

    // configuration registers
    logic signed [15:0] origin_x_reg, origin_y_reg;
    logic [15:0]        inv_x_reg, inv_y_reg;
    logic [6:0]         cols_reg, rows_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            inv_x_reg    <= 16'd256;
            inv_y_reg    <= 16'd256;
            cols_reg     <= 7'd64;
            rows_reg     <= 7'd64;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                CFG_INV_SP_X: inv_x_reg    <= cfg_data;
                CFG_INV_SP_Y: inv_y_reg    <= cfg_data;
                CFG_COLS:     cols_reg     <= cfg_data[6:0];
                CFG_ROWS:     rows_reg     <= cfg_data[6:0];
                default:      ;
            endcase
        end
    end

    // global advance: move when output is free or being taken
    logic out_valid_reg;
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // valid bits of the front stages
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0; v1_reg <= 1'b0; v2_reg <= 1'b0;
            v3_reg <= 1'b0; v4_reg <= 1'b0; v5_reg <= 1'b0;
            v6_reg <= 1'b0; v7_reg <= 1'b0; v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_axis_tvalid;
            v1_reg <= v0_reg; v2_reg <= v1_reg; v3_reg <= v2_reg;
            v4_reg <= v3_reg; v5_reg <= v4_reg; v6_reg <= v5_reg;
            v7_reg <= v6_reg; v8_reg <= v7_reg;
        end
    end

    // stage 0: input capture
    logic [1:0]         f0_reg;
    logic [IDX_W-1:0]   col0_reg, row0_reg;
    logic signed [15:0] p0_reg [3];
    logic signed [15:0] d0_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f0_reg    <= s_axis_tuser;
            col0_reg  <= s_axis_tdata[5:0];
            row0_reg  <= s_axis_tdata[11:6];
            p0_reg[0] <= s_axis_tdata[27:12];
            p0_reg[1] <= s_axis_tdata[43:28];
            p0_reg[2] <= s_axis_tdata[59:44];
            d0_reg[0] <= s_axis_tdata[75:60];
            d0_reg[1] <= s_axis_tdata[91:76];
            d0_reg[2] <= s_axis_tdata[107:92];
        end
    end

    // stage 1: (p - origin) * inverse spacing, Q16.16
    logic signed [16:0] rel_x, rel_y, inv_x_s, inv_y_s;
    logic signed [32:0] prod_x_next, prod_y_next;
    logic signed [32:0] prod_x_reg, prod_y_reg;
    logic [1:0]         f1_reg;
    logic [IDX_W-1:0]   col1_reg, row1_reg;
    logic signed [15:0] p1_reg [3];
    logic signed [15:0] d1_reg [3];

    always_comb
    begin
        rel_x       = 17'(p0_reg[0]) - 17'(origin_x_reg);
        rel_y       = 17'(p0_reg[1]) - 17'(origin_y_reg);
        inv_x_s     = $signed({1'b0, inv_x_reg});
        inv_y_s     = $signed({1'b0, inv_y_reg});
        prod_x_next = rel_x * inv_x_s;
        prod_y_next = rel_y * inv_y_s;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            f1_reg     <= f0_reg;
            col1_reg   <= col0_reg;
            row1_reg   <= row0_reg;
            p1_reg     <= p0_reg;
            d1_reg     <= d0_reg;
        end
    end

    // stage 2: locate cell, choose triangle, form corner addresses
    loc_t                   loc_x, loc_y;
    logic [IDX_W-1:0]       r2c, c2c, r3c, c3c;
    logic [GRID_ADDR_W-1:0] addr_c_next, addr_2_next, addr_3_next;
    logic                   clamp2_next;
    logic [GRID_ADDR_W-1:0] addr_c_reg, addr_2_reg, addr_3_reg, waddr_reg;
    logic                   clamp2_reg;
    logic [1:0]             f2_reg;
    logic signed [15:0]     p2_reg [3];
    logic signed [15:0]     d2_reg [3];

    always_comb
    begin
        loc_x = hftd_locate(prod_x_reg, cols_reg, 7'(GRID_COLS));
        loc_y = hftd_locate(prod_y_reg, rows_reg, 7'(GRID_ROWS));
        if (loc_x.frac < loc_y.frac)
        begin
            r2c = loc_y.cell_idx + 1'b1; c2c = loc_x.cell_idx + 1'b1;
            r3c = loc_y.cell_idx + 1'b1; c3c = loc_x.cell_idx;
        end
        else
        begin
            r2c = loc_y.cell_idx;        c2c = loc_x.cell_idx + 1'b1;
            r3c = loc_y.cell_idx + 1'b1; c3c = loc_x.cell_idx + 1'b1;
        end
        addr_c_next = {loc_y.cell_idx, loc_x.cell_idx};
        addr_2_next = {r2c, c2c};
        addr_3_next = {r3c, c3c};
        clamp2_next = loc_x.clamped | loc_y.clamped;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            addr_c_reg <= addr_c_next;
            addr_2_reg <= addr_2_next;
            addr_3_reg <= addr_3_next;
            waddr_reg  <= {row1_reg, col1_reg};
            clamp2_reg <= clamp2_next;
            f2_reg     <= f1_reg;
            p2_reg     <= p1_reg;
            d2_reg     <= d1_reg;
        end
    end

    // grid store: three copies, one read port per triangle corner
    logic        grid_we;
    logic [47:0] grid_wdata;
    logic [47:0] word_c, word_2, word_3;

    assign grid_we    = en && v2_reg && (f2_reg == FUNC_LOAD);
    assign grid_wdata = {p2_reg[2], p2_reg[1], p2_reg[0]};

    hftd_ram #(.WIDTH(48), .DEPTH(GRID_DEPTH)) u_ram_c (
        .clk(clk), .we(grid_we), .waddr(waddr_reg), .wdata(grid_wdata),
        .re(en), .raddr(addr_c_reg), .rdata(word_c)
    );
    hftd_ram #(.WIDTH(48), .DEPTH(GRID_DEPTH)) u_ram_2 (
        .clk(clk), .we(grid_we), .waddr(waddr_reg), .wdata(grid_wdata),
        .re(en), .raddr(addr_2_reg), .rdata(word_2)
    );
    hftd_ram #(.WIDTH(48), .DEPTH(GRID_DEPTH)) u_ram_3 (
        .clk(clk), .we(grid_we), .waddr(waddr_reg), .wdata(grid_wdata),
        .re(en), .raddr(addr_3_reg), .rdata(word_3)
    );

    // stage 3: side data beside the RAM read
    logic               clamp3_reg;
    logic [1:0]         f3_reg;
    logic signed [15:0] p3_reg [3];
    logic signed [15:0] d3_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            clamp3_reg <= clamp2_reg;
            f3_reg     <= f2_reg;
            p3_reg     <= p2_reg;
            d3_reg     <= d2_reg;
        end
    end

    // stage 4: triangle sides and point offset
    logic signed [16:0] s1_next [3];
    logic signed [16:0] s2_next [3];
    logic signed [16:0] pc_next [3];
    logic signed [16:0] s1_reg [3];
    logic signed [16:0] s2_reg [3];
    logic signed [16:0] pc4_reg [3];
    logic               clamp4_reg;
    logic [1:0]         f4_reg;
    logic signed [15:0] d4_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s1_next[k] = 17'($signed(word_2[16*k +: 16]))
                       - 17'($signed(word_c[16*k +: 16]));
            s2_next[k] = 17'($signed(word_3[16*k +: 16]))
                       - 17'($signed(word_c[16*k +: 16]));
            pc_next[k] = 17'(p3_reg[k]) - 17'($signed(word_c[16*k +: 16]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
            pc4_reg    <= pc_next;
            clamp4_reg <= clamp3_reg;
            f4_reg     <= f3_reg;
            d4_reg     <= d3_reg;
        end
    end

    // stage 5: cross product partial products
    logic signed [33:0] xp_reg [6];
    logic signed [33:0] xp_next [6];
    logic signed [16:0] pc5_reg [3];
    logic               clamp5_reg;
    logic [1:0]         f5_reg;
    logic signed [15:0] d5_reg [3];

    always_comb
    begin
        xp_next[0] = s1_reg[1] * s2_reg[2];
        xp_next[1] = s1_reg[2] * s2_reg[1];
        xp_next[2] = s1_reg[2] * s2_reg[0];
        xp_next[3] = s1_reg[0] * s2_reg[2];
        xp_next[4] = s1_reg[0] * s2_reg[1];
        xp_next[5] = s1_reg[1] * s2_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xp_reg     <= xp_next;
            pc5_reg    <= pc4_reg;
            clamp5_reg <= clamp4_reg;
            f5_reg     <= f4_reg;
            d5_reg     <= d4_reg;
        end
    end

    // stage 6: normal vector
    logic signed [33:0] n_reg [3];
    logic signed [16:0] pc6_reg [3];
    logic               clamp6_reg;
    logic [1:0]         f6_reg;
    logic signed [15:0] d6_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]   <= xp_reg[0] - xp_reg[1];
            n_reg[1]   <= xp_reg[2] - xp_reg[3];
            n_reg[2]   <= xp_reg[4] - xp_reg[5];
            pc6_reg    <= pc5_reg;
            clamp6_reg <= clamp5_reg;
            f6_reg     <= f5_reg;
            d6_reg     <= d5_reg;
        end
    end

    // stage 7: dot product terms
    logic signed [50:0] pn_next [3];
    logic signed [49:0] dn_next [3];
    logic signed [50:0] pn_reg [3];
    logic signed [49:0] dn_reg [3];
    logic               clamp7_reg;
    logic [1:0]         f7_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pn_next[k] = pc6_reg[k] * n_reg[k];
            dn_next[k] = d6_reg[k] * n_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pn_reg     <= pn_next;
            dn_reg     <= dn_next;
            clamp7_reg <= clamp6_reg;
            f7_reg     <= f6_reg;
        end
    end

    // stage 8: numerator and denominator sums
    logic signed [52:0] num_reg;
    logic signed [50:0] den_reg;
    logic               clamp8_reg;
    logic [1:0]         f8_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg    <= 53'(pn_reg[0]) + 53'(pn_reg[1]) + 53'(pn_reg[2]);
            den_reg    <= 51'(dn_reg[0]) + 51'(dn_reg[1]) + 51'(dn_reg[2]);
            clamp8_reg <= clamp7_reg;
            f8_reg     <= f7_reg;
        end
    end

    // stage 9: divider set-up, and results for items that skip division
    div_stage_t  div_in_next, div_in_reg, div_out;
    logic [52:0] un;
    logic [50:0] ud;
    logic [1:0]  st_query;
    logic [51:0] plane_val;

    always_comb
    begin
        un        = num_reg[52] ? 53'(-num_reg) : 53'(num_reg);
        ud        = den_reg[50] ? 51'(-den_reg) : 51'(den_reg);
        st_query  = clamp8_reg ? ST_CLAMPED : ST_OK;
        if (num_reg > $signed({1'b0, VAL_MAX}))
            plane_val = VAL_MAX;
        else if (num_reg < -$signed({1'b0, VAL_CAP}))
            plane_val = VAL_CAP;
        else
            plane_val = num_reg[51:0];

        div_in_next.valid  = v8_reg;
        div_in_next.divide = 1'b0;
        div_in_next.neg    = num_reg[52] == den_reg[50];
        div_in_next.ovf    = 76'(un) >= (76'(ud) << 22);
        div_in_next.ud     = ud;
        div_in_next.rem    = 51'(un >> 22);
        div_in_next.un_lo  = un[21:0];
        div_in_next.q      = '0;
        div_in_next.status = ST_OK;
        div_in_next.value  = '0;
        case (f8_reg)
            FUNC_LOAD:
                div_in_next.status = ST_LOADED;
            FUNC_PLANE:
            begin
                div_in_next.status = st_query;
                div_in_next.value  = plane_val;
            end
            FUNC_DIR:
            begin
                if (den_reg == '0)
                    div_in_next.status = ST_PARALLEL;
                else
                begin
                    div_in_next.status = st_query;
                    div_in_next.divide = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_in_reg.valid <= 1'b0;
        else if (en)
            div_in_reg <= div_in_next;
    end

    hftd_divider u_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_stage(div_in_reg), .out_stage(div_out)
    );

    // output register: sign and saturate the quotient
    logic [51:0] out_value_next, out_value_reg;
    logic [51:0] mag;
    logic [1:0]  out_status_reg;

    always_comb
    begin
        mag            = '0;
        out_value_next = div_out.value;
        if (div_out.divide)
        begin
            if (div_out.neg)
            begin
                mag            = (div_out.ovf || div_out.q > VAL_CAP) ? VAL_CAP : div_out.q;
                out_value_next = 52'(-mag);
            end
            else
                out_value_next = (div_out.ovf || div_out.q >= VAL_CAP) ? VAL_MAX : div_out.q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= div_out.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_value_reg  <= out_value_next;
            out_status_reg <= div_out.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_value_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

FILE: sv/hftd_checker.sv
// Port-level checker for the heightfield triangle distance unit, with its bind.
module hftd_checker
    import hftd_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [111:0] s_axis_tdata,
    input logic [1:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [55:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [2:0]   cfg_index,
    input logic [15:0]  cfg_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // input back-pressure only comes from a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

    // loads and parallel directions carry a zero value
    a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_LOADED || m_axis_tuser == ST_PARALLEL)
        |-> m_axis_tdata == '0)
        else $error("non-zero value with load or parallel status");

    // configuration writes are never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind heightfield_triangle_distance_unit hftd_checker u_hftd_checker (.*);
